// ===== hdl/scb_pkg.sv =====
package scb_pkg;

	// Field and port widths.
	localparam int PIX_W      = 8;
	localparam int CFG_W      = 8;
	localparam int CFG_ADDR_W = 2;
	localparam int NUM_LANES  = 3;

	// Configuration register indexes and reset values.
	localparam logic [CFG_ADDR_W-1:0] REG_CONTRAST   = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_BRIGHTNESS = 2'd1;
	localparam logic [CFG_W-1:0]      CONTRAST_RST   = 8'd20;
	localparam logic [CFG_W-1:0]      BRIGHTNESS_RST = 8'd100;

	// Steepness: t = round(|v-127| * contrast * 4096 / 2550) in Q12.
	localparam logic [PIX_W-1:0] MID_LEVEL   = 8'd127;
	localparam int               T_DIVISOR   = 2550;
	localparam logic [26:0]      T_ROUND     = 27'd1275;
	localparam int               RECIP_SHIFT = 40;
	localparam logic [28:0]      RECIP_T     = 29'((64'd1 << RECIP_SHIFT) / 64'd2550);

	// Exponent and sigmoid constants.
	localparam logic [16:0] LOG2E_Q16    = 17'd94548;
	localparam logic [24:0] ONE_Q24      = 25'h100_0000;
	localparam logic [16:0] GAIN_OFS_Q16 = 17'd19661;
	localparam logic [9:0]  BRIGHT_BIAS  = 10'd100;

	// 2^-(2^(k-12)) in Q24, indexed by the bit position k of the fraction.
	localparam logic [23:0] POW2_FRAC [12] = '{
		24'd16774377, 24'd16771539, 24'd16765863, 24'd16754518,
		24'd16731851, 24'd16686609, 24'd16596492, 24'd16417715,
		24'd16065917, 24'd15384774, 24'd14107901, 24'd11863283
	};
	localparam int FRAC_BITS = 12;
	localparam int QUOT_BITS = 17;

	// Pipeline depth of one lane, and of the whole block with the merge stage.
	localparam int LANE_LAT = 4 + FRAC_BITS + 1 + QUOT_BITS + 3;
	localparam int SCB_LAT  = LANE_LAT + 1;

	typedef struct packed {
		logic [PIX_W-1:0] chan0_in;
		logic [PIX_W-1:0] chan1_in;
		logic [PIX_W-1:0] chan2_in;
	} pixel_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] chan0_out;
		logic [PIX_W-1:0] chan1_out;
		logic [PIX_W-1:0] chan2_out;
	} pixel_out_t;

	// Values that ride along a lane's long pipeline.
	typedef struct packed {
		logic [PIX_W-1:0] v;
		logic             neg;
		logic [4:0]       n;
	} lane_side_t;

endpackage

// ===== hdl/scb_pow2_step.sv =====
module scb_pow2_step import scb_pkg::*; (
	input  logic        clk,
	input  logic [24:0] e,
	input  logic [FRAC_BITS-1:0] f,
	input  lane_side_t  side,
	input  logic [23:0] coef,
	output logic [24:0] e_s1,
	output logic [FRAC_BITS-1:0] f_s1,
	output lane_side_t  side_s1
);

	localparam logic [48:0] HALF_Q24 = 49'h80_0000;

	logic [48:0] prod;
	logic [48:0] prod_rnd;

	// Multiply by the power-of-two factor of the current fraction bit, rounded.
	assign prod     = e * coef;
	assign prod_rnd = prod + HALF_Q24;

	// One fraction bit per stage; the fraction shifts down to present the next.
	always_ff @(posedge clk) begin
		e_s1    <= f[0] ? prod_rnd[48:24] : e;
		f_s1    <= f >> 1;
		side_s1 <= side;
	end

endmodule

// ===== hdl/scb_div_step.sv =====
module scb_div_step import scb_pkg::*; (
	input  logic        clk,
	input  logic [25:0] r,
	input  logic [QUOT_BITS-1:0] bits,
	input  logic [25:0] d,
	input  lane_side_t  side,
	output logic [25:0] r_s1,
	output logic [QUOT_BITS-1:0] bits_s1,
	output logic [25:0] d_s1,
	output lane_side_t  side_s1
);

	logic [26:0] trial;
	logic [26:0] diff;
	logic        ge;

	// Bring down the next dividend bit and try to subtract the divisor.
	assign trial = {r, bits[QUOT_BITS-1]};
	assign ge    = trial >= {1'b0, d};
	assign diff  = trial - {1'b0, d};

	// Dividend bits leave at the top while quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		r_s1    <= ge ? diff[25:0] : trial[25:0];
		bits_s1 <= {bits[QUOT_BITS-2:0], ge};
		d_s1    <= d;
		side_s1 <= side;
	end

endmodule

// ===== hdl/scb_lane.sv =====
module scb_lane import scb_pkg::*; (
	input  logic             clk,
	input  logic [CFG_W-1:0] contrast,
	input  logic [CFG_W-1:0] brightness,
	input  logic [PIX_W-1:0] v,
	output logic [PIX_W-1:0] res
);

	// Stage 1: magnitude of (v - 127) times contrast.
	logic [PIX_W-1:0] ad;
	logic [15:0]      prod_a;
	logic [PIX_W-1:0] v_s1;
	logic             neg_s1;
	logic [14:0]      a_s1;

	assign ad     = (v < MID_LEVEL) ? (MID_LEVEL - v) : (v - MID_LEVEL);
	assign prod_a = ad * contrast;

	always_ff @(posedge clk) begin
		v_s1   <= v;
		neg_s1 <= v < MID_LEVEL;
		a_s1   <= prod_a[14:0];
	end

	// Stage 2: estimate of the quotient by 2550 through the reciprocal.
	logic [26:0]      x;
	logic [55:0]      xm;
	logic [PIX_W-1:0] v_s2;
	logic             neg_s2;
	logic [26:0]      x_s2;
	logic [15:0]      q0_s2;

	assign x  = {a_s1, 12'd0} + T_ROUND;
	assign xm = x * RECIP_T;

	always_ff @(posedge clk) begin
		v_s2   <= v_s1;
		neg_s2 <= neg_s1;
		x_s2   <= x;
		q0_s2  <= xm[55:40];
	end

	// Stage 3: the estimate is at most one low; one compare fixes it.
	logic [26:0]      qm;
	logic [26:0]      rem;
	logic [PIX_W-1:0] v_s3;
	logic             neg_s3;
	logic [15:0]      q_s3;

	assign qm  = q0_s2 * 27'(T_DIVISOR);
	assign rem = x_s2 - qm;

	always_ff @(posedge clk) begin
		v_s3   <= v_s2;
		neg_s3 <= neg_s2;
		q_s3   <= (rem >= 27'(T_DIVISOR)) ? q0_s2 + 16'd1 : q0_s2;
	end

	// Stage 4: |t| * log2(e), split into integer and fraction of the exponent.
	logic [32:0]          uw;
	logic [FRAC_BITS-1:0] f_s4;
	lane_side_t           side_s4;

	assign uw = q_s3 * LOG2E_Q16 + 33'd32768;

	always_ff @(posedge clk) begin
		f_s4         <= uw[16 +: FRAC_BITS];
		side_s4.v    <= v_s3;
		side_s4.neg  <= neg_s3;
		side_s4.n    <= uw[32:28];
	end

	// Fraction power of two: one rounded multiply per fraction bit.
	logic [24:0]          e_c    [FRAC_BITS+1];
	logic [FRAC_BITS-1:0] f_c    [FRAC_BITS+1];
	lane_side_t           side_c [FRAC_BITS+1];

	assign e_c[0]    = ONE_Q24;
	assign f_c[0]    = f_s4;
	assign side_c[0] = side_s4;

	for (genvar k = 0; k < FRAC_BITS; k++) begin : g_pow
		scb_pow2_step u_pow (
			.clk     (clk),
			.e       (e_c[k]),
			.f       (f_c[k]),
			.side    (side_c[k]),
			.coef    (POW2_FRAC[k]),
			.e_s1    (e_c[k+1]),
			.f_s1    (f_c[k+1]),
			.side_s1 (side_c[k+1])
		);
	end

	// Integer part of the exponent, then the divisor and dividend of the sigmoid.
	logic [24:0]          e_sh;
	logic [25:0]          dd;
	logic [40:0]          nn;
	logic [25:0]          r_init_s17;
	logic [QUOT_BITS-1:0] bits_init_s17;
	logic [25:0]          d_s17;
	lane_side_t           side_s17;

	assign e_sh = e_c[FRAC_BITS] >> side_c[FRAC_BITS].n;
	assign dd   = {1'b0, ONE_Q24} + {1'b0, e_sh};
	assign nn   = (41'd1 << 40) + {16'd0, dd[25:1]};

	always_ff @(posedge clk) begin
		r_init_s17    <= {2'b00, nn[40:QUOT_BITS]};
		bits_init_s17 <= nn[QUOT_BITS-1:0];
		d_s17         <= dd;
		side_s17      <= side_c[FRAC_BITS];
	end

	// Restoring division, one quotient bit per stage.
	logic [25:0]          r_c    [QUOT_BITS+1];
	logic [QUOT_BITS-1:0] bits_c [QUOT_BITS+1];
	logic [25:0]          d_c    [QUOT_BITS+1];
	lane_side_t           sd_c   [QUOT_BITS+1];

	assign r_c[0]    = r_init_s17;
	assign bits_c[0] = bits_init_s17;
	assign d_c[0]    = d_s17;
	assign sd_c[0]   = side_s17;

	for (genvar k = 0; k < QUOT_BITS; k++) begin : g_div
		scb_div_step u_div (
			.clk     (clk),
			.r       (r_c[k]),
			.bits    (bits_c[k]),
			.d       (d_c[k]),
			.side    (sd_c[k]),
			.r_s1    (r_c[k+1]),
			.bits_s1 (bits_c[k+1]),
			.d_s1    (d_c[k+1]),
			.side_s1 (sd_c[k+1])
		);
	end

	// Sigmoid from the symmetric half, plus the gain offset of 0.3.
	logic [16:0]      p;
	logic [16:0]      sg;
	logic [16:0]      g_s35;
	logic [PIX_W-1:0] v_s35;

	assign p  = bits_c[QUOT_BITS];
	assign sg = sd_c[QUOT_BITS].neg ? (17'h1_0000 - p)
	          : ((p > 17'h0_FFFF) ? 17'h0_FFFF : p);

	always_ff @(posedge clk) begin
		g_s35 <= sg + GAIN_OFS_Q16;
		v_s35 <= sd_c[QUOT_BITS].v;
	end

	// Scale the channel and add the brightness offset in Q16.
	logic [24:0]        vg;
	logic signed [9:0]  off;
	logic signed [26:0] off_w;
	logic signed [26:0] y_s36;

	assign vg    = v_s35 * g_s35;
	assign off   = $signed({2'b00, brightness}) - $signed(BRIGHT_BIAS);
	assign off_w = 27'(off);

	always_ff @(posedge clk) begin
		y_s36 <= $signed({2'b00, vg}) + (off_w <<< 16);
	end

	// Round half up and saturate to the pixel range.
	logic [26:0]      yr;
	logic [PIX_W-1:0] res_s37;

	assign yr = 27'(y_s36) + 27'd32768;

	always_ff @(posedge clk) begin
		if (y_s36 < 0) begin
			res_s37 <= '0;
		end else if (yr[26:16] > 11'd255) begin
			res_s37 <= '1;
		end else begin
			res_s37 <= yr[16 +: PIX_W];
		end
	end

	assign res = res_s37;

endmodule

// ===== hdl/sigmoid_contrast_brightness.sv =====
// Channel     Signals                              Direction
// ----------  -----------------------------------  ---------
// pixel in    start, pixel; busy is an output      in
// pixel out   done, adjusted                       out
// config      cfg_wr_en, cfg_addr, cfg_data        in
//
// A pixel is taken at every clock edge where start is high; busy stays low.
// Each pixel's result is computed by the per-lane pipeline of
// 12 fraction multiplies, 17 quotient-bit division stages and 8 other stages,
// plus the merge register. Throughput is one pixel per cycle.
// The asynchronous reset clears the valid line and returns the configuration
// registers to their default values.
// done is high for one cycle per result; the receiver takes it in that cycle.
module sigmoid_contrast_brightness import scb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  pixel_in_t             pixel,
	output logic                  done,
	output pixel_out_t            adjusted,
	input  logic                  cfg_wr_en,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]      cfg_data
);

	// Configuration registers; writes to other indexes are dropped.
	logic [CFG_W-1:0] contrast_q;
	logic [CFG_W-1:0] brightness_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			contrast_q   <= CONTRAST_RST;
			brightness_q <= BRIGHTNESS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_CONTRAST:   contrast_q   <= cfg_data;
				REG_BRIGHTNESS: brightness_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The pipeline never holds off a transfer.
	assign busy = 1'b0;

	// One lane per color channel.
	logic [PIX_W-1:0] lane_in  [NUM_LANES];
	logic [PIX_W-1:0] lane_out [NUM_LANES];

	assign lane_in[0] = pixel.chan0_in;
	assign lane_in[1] = pixel.chan1_in;
	assign lane_in[2] = pixel.chan2_in;

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		scb_lane u_lane (
			.clk        (clk),
			.contrast   (contrast_q),
			.brightness (brightness_q),
			.v          (lane_in[i]),
			.res        (lane_out[i])
		);
	end

	// Valid line that tracks each accepted pixel through the lanes.
	logic [LANE_LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LANE_LAT-2:0], start & ~busy};
		end
	end

	// Merge stage: gather the three lane results into one output transfer.
	logic       done_q;
	pixel_out_t adjusted_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_q[LANE_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (vld_q[LANE_LAT-1]) begin
			adjusted_q.chan0_out <= lane_out[0];
			adjusted_q.chan1_out <= lane_out[1];
			adjusted_q.chan2_out <= lane_out[2];
		end
	end

	assign done     = done_q;
	assign adjusted = adjusted_q;

endmodule

// ===== hdl/scb_checker.sv =====
module scb_checker import scb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// The block can take a pixel in every cycle: busy never rises.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// Every accepted pixel yields a result after the fixed latency.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##SCB_LAT done)
		else $error("result missing after accepted pixel");

	// No result without a pixel accepted the latency earlier.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, SCB_LAT))
		else $error("result without accepted pixel");

endmodule

bind sigmoid_contrast_brightness scb_checker u_scb_checker (.*);
